@@ design/scancode_to_ascii_decoder_top_assert.svh @@
// Assertion macros used by the decoder top level.
`ifndef SCANCODE_TO_ASCII_DECODER_TOP_ASSERT_SVH
`define SCANCODE_TO_ASCII_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SCTA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SCTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/scta_pkg.sv @@
`default_nettype none

package scta_pkg;

    // Scancode table geometry.
    localparam int          TBL_DEPTH = 84;
    localparam int          IDX_W     = 7;
    localparam logic [7:0]  SC_LAST   = 8'h53;

    // Default depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Set-1 modifier codes.
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
    localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
    localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] SC_INS_MAKE     = 8'h52;

    // Modifier combinations that select a table (shift is weight 1, insert 16).
    localparam logic [4:0] MODS_PLAIN          = 5'd0;
    localparam logic [4:0] MODS_SHIFT          = 5'd1;
    localparam logic [4:0] MODS_CTRL           = 5'd2;
    localparam logic [4:0] MODS_CAPS           = 5'd4;
    localparam logic [4:0] MODS_SHIFT_CAPS     = 5'd5;
    localparam logic [4:0] MODS_CAPS_CTRL      = 5'd6;
    localparam logic [4:0] MODS_ALT            = 5'd8;
    localparam logic [4:0] MODS_INS            = 5'd16;
    localparam logic [4:0] MODS_SHIFT_INS      = 5'd17;
    localparam logic [4:0] MODS_CAPS_INS       = 5'd20;
    localparam logic [4:0] MODS_CAPS_INS_SHIFT = 5'd21;

    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_LOWER,
        TBL_UPPER,
        TBL_CAPS
    } t_tbl_sel;

    // Packed so that the value matches the bit weights of the flags.
    typedef struct packed {
        logic insert_on;
        logic alt_on;
        logic caps_on;
        logic ctrl_on;
        logic shift_on;
    } t_mod_flags;

    // One classified word as it travels from the front end to the back end.
    typedef struct packed {
        logic [IDX_W-1:0] code_idx;
        t_tbl_sel         sel;
        logic             was_mod;
        t_mod_flags       flags;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Character tables, indexed by scancode.
    localparam logic [6:0] LOWER_TBL [TBL_DEPTH] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75,
        7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67,
        7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63,
        7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
        7'h3B,
        7'h3C, 7'h3D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h37, 7'h38, 7'h39, 7'h2D, 7'h34,
        7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30, 7'h2E
    };

    localparam logic [6:0] UPPER_TBL [TBL_DEPTH] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
        7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55,
        7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47,
        7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h27, 7'h60, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43,
        7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
        7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h37, 7'h38, 7'h39, 7'h2D, 7'h34,
        7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30, 7'h2E
    };

    localparam logic [6:0] CAPS_TBL [TBL_DEPTH] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h2D, 7'h3D, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55,
        7'h49, 7'h4F, 7'h50, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47,
        7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h5A, 7'h58, 7'h43,
        7'h56, 7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
        7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h37, 7'h38, 7'h39, 7'h2D, 7'h34,
        7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30, 7'h2E
    };

endpackage

`default_nettype wire

@@ design/scancode_to_ascii_decoder_top.sv @@
`default_nettype none

`include "scancode_to_ascii_decoder_top_assert.svh"

// Set-1 scancode decoder: every accepted scancode byte gives exactly one result word
// holding the translated character (0 when none), a valid flag, a modifier marker and
// the shift, ctrl, caps, alt and insert state after that byte. One byte is accepted per
// clock cycle while the queue has room; the byte is written into the queue and its result
// then goes from the queue head into the output register. The front end updates the modifier
// flags and picks the table, a queue of QUEUE_DEPTH words decouples it from the back end,
// and the back end does the table lookup. The input stalls only while that queue is full.
module scancode_to_ascii_decoder_top #(
    parameter int QUEUE_DEPTH = scta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_scan_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_ascii_char,
    output logic       o_char_valid,
    output logic       o_was_modifier,
    output logic       o_shift_on,
    output logic       o_ctrl_on,
    output logic       o_caps_on,
    output logic       o_alt_on,
    output logic       o_insert_on
);
    import scta_pkg::*;

    t_q_status  w_q_status;
    t_item      w_push_item;
    t_item      w_head_item;
    t_mod_flags w_flags;
    logic       w_push;
    logic       w_pop;

    // Front end: flag update and table choice.
    scta_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_scan_byte(i_scan_byte),
        .i_q_status (w_q_status),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_item     (w_push_item),
        .o_flags    (w_flags)
    );

    // Queue between the two ends.
    scta_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_status(w_q_status)
    );

    // Back end: table lookup and output register.
    scta_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_item        (w_head_item),
        .i_out_stall   (i_out_stall),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .o_ascii_char  (o_ascii_char),
        .o_char_valid  (o_char_valid),
        .o_was_modifier(o_was_modifier),
        .o_shift_on    (o_shift_on),
        .o_ctrl_on     (o_ctrl_on),
        .o_caps_on     (o_caps_on),
        .o_alt_on      (o_alt_on),
        .o_insert_on   (o_insert_on)
    );

    // A modifier word never carries a character.
    `SCTA_ASSERT_IMPL(a_mod_no_char, i_clk, i_rst_n, o_out_valid && o_was_modifier,
        !o_char_valid, "modifier word carries a character")

    // The queue cannot be full and empty at once.
    `SCTA_ASSERT_IMPL(a_queue_level, i_clk, i_rst_n, w_q_status.full, !w_q_status.empty,
        "queue reports full and empty together")

    // An accepted caps make code flips the caps flag.
    `SCTA_ASSERT_NEXT(a_caps_toggle, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_scan_byte == SC_CAPS_MAKE),
        w_flags.caps_on != $past(w_flags.caps_on), "caps flag did not toggle")

endmodule

`default_nettype wire

@@ design/scta_front.sv @@
`default_nettype none

module scta_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [7:0]          i_scan_byte,
    input  scta_pkg::t_q_status i_q_status,
    output logic                o_in_stall,
    output logic                o_push,
    output scta_pkg::t_item     o_item,
    output scta_pkg::t_mod_flags o_flags
);
    import scta_pkg::*;

    t_mod_flags r_flags;
    t_mod_flags n_flags;
    logic       w_mod;
    logic       w_accept;
    t_tbl_sel   w_sel;

    // A word is taken whenever the queue has room.
    assign o_in_stall = i_q_status.full;
    assign w_accept   = i_in_valid && !i_q_status.full;

    // Modifier decode and flag update.
    always_comb begin
        n_flags = r_flags;
        w_mod   = 1'b1;
        unique case (i_scan_byte) inside
            SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   n_flags.shift_on  = 1'b1;
            SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: n_flags.shift_on  = 1'b0;
            SC_CTRL_MAKE:                     n_flags.ctrl_on   = 1'b1;
            SC_CTRL_BREAK:                    n_flags.ctrl_on   = 1'b0;
            SC_ALT_MAKE:                      n_flags.alt_on    = 1'b1;
            SC_ALT_BREAK:                     n_flags.alt_on    = 1'b0;
            SC_CAPS_MAKE:                     n_flags.caps_on   = !r_flags.caps_on;
            SC_INS_MAKE:                      n_flags.insert_on = !r_flags.insert_on;
            default:                          w_mod             = 1'b0;
        endcase
    end

    // Table choice from the exact modifier combination.
    always_comb begin
        w_sel = TBL_NONE;
        if (!w_mod && (i_scan_byte <= SC_LAST)) begin
            unique case (n_flags) inside
                MODS_PLAIN, MODS_CTRL, MODS_ALT, MODS_INS:
                    w_sel = TBL_LOWER;
                MODS_SHIFT, MODS_SHIFT_CAPS, MODS_SHIFT_INS:
                    w_sel = TBL_UPPER;
                MODS_CAPS, MODS_CAPS_CTRL, MODS_CAPS_INS, MODS_CAPS_INS_SHIFT:
                    w_sel = TBL_CAPS;
                default:
                    w_sel = TBL_NONE;
            endcase
        end
    end

    // Flag register advances once per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (w_accept) begin
            r_flags <= n_flags;
        end
    end

    assign o_push          = w_accept;
    assign o_item.code_idx = i_scan_byte[IDX_W-1:0];
    assign o_item.sel      = w_sel;
    assign o_item.was_mod  = w_mod;
    assign o_item.flags    = n_flags;
    assign o_flags         = r_flags;

endmodule

`default_nettype wire

@@ design/scta_queue.sv @@
`default_nettype none

module scta_queue #(
    parameter int DEPTH = scta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  scta_pkg::t_item     i_item,
    input  logic                i_pop,
    output scta_pkg::t_item     o_item,
    output scta_pkg::t_q_status o_status
);
    import scta_pkg::*;

    localparam int               PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int               CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL  = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FULL);
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

@@ design/scta_back.sv @@
`default_nettype none

module scta_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scta_pkg::t_q_status i_q_status,
    input  scta_pkg::t_item     i_item,
    input  logic                i_out_stall,
    output logic                o_pop,
    output logic                o_out_valid,
    output logic [6:0]          o_ascii_char,
    output logic                o_char_valid,
    output logic                o_was_modifier,
    output logic                o_shift_on,
    output logic                o_ctrl_on,
    output logic                o_caps_on,
    output logic                o_alt_on,
    output logic                o_insert_on
);
    import scta_pkg::*;

    logic       r_valid;
    logic [6:0] r_char;
    logic       r_was_mod;
    t_mod_flags r_flags;
    logic       w_load;
    logic [6:0] w_char;

    // Take the head of the queue whenever the output register is free or drains.
    assign w_load = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign o_pop  = w_load;

    // Character lookup in the selected table.
    always_comb begin
        unique case (i_item.sel)
            TBL_LOWER: w_char = LOWER_TBL[i_item.code_idx];
            TBL_UPPER: w_char = UPPER_TBL[i_item.code_idx];
            TBL_CAPS:  w_char = CAPS_TBL[i_item.code_idx];
            default:   w_char = '0;
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char    <= w_char;
            r_was_mod <= i_item.was_mod;
            r_flags   <= i_item.flags;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_ascii_char   = r_char;
    assign o_char_valid   = (r_char != '0);
    assign o_was_modifier = r_was_mod;
    assign o_shift_on     = r_flags.shift_on;
    assign o_ctrl_on      = r_flags.ctrl_on;
    assign o_caps_on      = r_flags.caps_on;
    assign o_alt_on       = r_flags.alt_on;
    assign o_insert_on    = r_flags.insert_on;

endmodule

`default_nettype wire

@@ test/keystroke_checker.sv @@
`default_nettype none

// Watches both channels of the scancode decoder, predicts every result word
// from the accepted scancode words and compares them in order.
module keystroke_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_scan_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [6:0] i_ascii_char,
    input  logic       i_char_valid,
    input  logic       i_was_modifier,
    input  logic       i_shift_on,
    input  logic       i_ctrl_on,
    input  logic       i_caps_on,
    input  logic       i_alt_on,
    input  logic       i_insert_on,
    output int         o_mismatch_count,
    output int         o_keystrokes_pending
);
    import scta_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       char_valid;
        logic       was_modifier;
        t_mod_flags flags;
    } t_keystroke;

    // Character maps of a US layout, indexed by make code.
    localparam bit [6:0] LOWER_CHARS [84] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75,
        7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67,
        7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63,
        7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
        7'h3B, 7'h3C, 7'h3D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30,
        7'h2E
    };

    localparam bit [6:0] UPPER_CHARS [84] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
        7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55,
        7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47,
        7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h27, 7'h60, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43,
        7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30,
        7'h2E
    };

    localparam bit [6:0] CAPS_CHARS [84] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h2D, 7'h3D, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55,
        7'h49, 7'h4F, 7'h50, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47,
        7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h5A, 7'h58, 7'h43,
        7'h56, 7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30,
        7'h2E
    };

    t_mod_flags mod_flags;
    t_keystroke expected_keystrokes [$];

    // Updates the modifier state with one scancode and returns the word it gives.
    function automatic t_keystroke decode_scancode(input logic [7:0] code);
        t_keystroke result;
        t_tbl_sel   map_sel;
        result              = '0;
        result.was_modifier = 1'b1;
        case (code)
            SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   mod_flags.shift_on  = 1'b1;
            SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: mod_flags.shift_on  = 1'b0;
            SC_CTRL_MAKE:                     mod_flags.ctrl_on   = 1'b1;
            SC_CTRL_BREAK:                    mod_flags.ctrl_on   = 1'b0;
            SC_ALT_MAKE:                      mod_flags.alt_on    = 1'b1;
            SC_ALT_BREAK:                     mod_flags.alt_on    = 1'b0;
            SC_CAPS_MAKE:                     mod_flags.caps_on   = ~mod_flags.caps_on;
            SC_INS_MAKE:                      mod_flags.insert_on = ~mod_flags.insert_on;
            default:                          result.was_modifier = 1'b0;
        endcase

        // Only the listed modifier combinations pick a map; the rest give nothing.
        if (!result.was_modifier && code <= SC_LAST) begin
            case (mod_flags)
                MODS_PLAIN, MODS_CTRL, MODS_ALT, MODS_INS: map_sel = TBL_LOWER;
                MODS_SHIFT, MODS_SHIFT_CAPS, MODS_SHIFT_INS: map_sel = TBL_UPPER;
                MODS_CAPS, MODS_CAPS_CTRL, MODS_CAPS_INS, MODS_CAPS_INS_SHIFT: begin
                    map_sel = TBL_CAPS;
                end
                default: map_sel = TBL_NONE;
            endcase
            case (map_sel)
                TBL_LOWER: result.ascii_char = LOWER_CHARS[code];
                TBL_UPPER: result.ascii_char = UPPER_CHARS[code];
                TBL_CAPS:  result.ascii_char = CAPS_CHARS[code];
                default:   result.ascii_char = '0;
            endcase
        end
        result.char_valid = (result.ascii_char != '0);
        result.flags      = mod_flags;
        return result;
    endfunction

    task automatic check_field(input string name, input logic [6:0] want,
                               input logic [6:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            o_mismatch_count++;
        end
    endtask

    // Predict on every accepted scancode word, compare on every accepted result word.
    always @(posedge i_clk) begin
        t_keystroke want;
        if (!i_rst_n) begin
            mod_flags = '0;
            expected_keystrokes.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_keystrokes.push_back(decode_scancode(i_scan_byte));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_keystrokes.size() == 0) begin
                    $error("result word with no scancode word outstanding");
                    o_mismatch_count++;
                end else begin
                    want = expected_keystrokes.pop_front();
                    check_field("ascii_char", want.ascii_char, i_ascii_char);
                    check_field("char_valid", 7'(want.char_valid), 7'(i_char_valid));
                    check_field("was_modifier", 7'(want.was_modifier), 7'(i_was_modifier));
                    check_field("shift_on", 7'(want.flags.shift_on), 7'(i_shift_on));
                    check_field("ctrl_on", 7'(want.flags.ctrl_on), 7'(i_ctrl_on));
                    check_field("caps_on", 7'(want.flags.caps_on), 7'(i_caps_on));
                    check_field("alt_on", 7'(want.flags.alt_on), 7'(i_alt_on));
                    check_field("insert_on", 7'(want.flags.insert_on), 7'(i_insert_on));
                end
            end
        end
        o_keystrokes_pending = expected_keystrokes.size();
    end

endmodule

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
    import scta_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] BREAK_BIT      = 8'h80;
    localparam int         TOTAL_WORDS    = 1980;
    localparam int         PRESSURE_AT    = 600;
    localparam int         LONG_HOLD      = 80;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] scan_byte = '0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [6:0] ascii_char;
    logic       char_valid;
    logic       was_modifier;
    logic       shift_on;
    logic       ctrl_on;
    logic       caps_on;
    logic       alt_on;
    logic       insert_on;

    int  mismatch_count;
    int  keystrokes_pending;
    int  words_sent = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    bit  hold_request = 1'b0;
    bit  idle_en;

    always #5 clk = ~clk;

    scancode_to_ascii_decoder_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_scan_byte    (scan_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_ascii_char   (ascii_char),
        .o_char_valid   (char_valid),
        .o_was_modifier (was_modifier),
        .o_shift_on     (shift_on),
        .o_ctrl_on      (ctrl_on),
        .o_caps_on      (caps_on),
        .o_alt_on       (alt_on),
        .o_insert_on    (insert_on)
    );

    keystroke_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_stall           (in_stall),
        .i_scan_byte          (scan_byte),
        .i_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .i_ascii_char         (ascii_char),
        .i_char_valid         (char_valid),
        .i_was_modifier       (was_modifier),
        .i_shift_on           (shift_on),
        .i_ctrl_on            (ctrl_on),
        .i_caps_on            (caps_on),
        .i_alt_on             (alt_on),
        .i_insert_on          (insert_on),
        .o_mismatch_count     (mismatch_count),
        .o_keystrokes_pending (keystrokes_pending)
    );

    // Idle bursts come and go, with a quiet stretch in the middle and none at the end.
    assign idle_en = (words_sent < 1200) || (words_sent >= 1400 && words_sent < 1750);

    // Offers one scancode word, possibly after a short gap, and waits until it is taken.
    task automatic send_scancode(input logic [7:0] code);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        scan_byte <= code;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Receiver side: short random stall bursts, plus one long hold-off on request.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (hold_request) begin
            hold_request = 1'b0;
            out_stall <= 1'b1;
            stall_left = LONG_HOLD - 1;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 4);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Ends the run if neither channel moves a word for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [7:0] directed_codes [] = '{
            8'h00, 8'hFF, 8'h10, SC_LAST, 8'h90,
            SC_CTRL_MAKE, 8'h1E, SC_CTRL_BREAK,
            SC_ALT_MAKE, 8'h3B, SC_ALT_BREAK,
            SC_LSHIFT_MAKE, 8'h02, 8'h3B, SC_LSHIFT_BREAK,
            SC_CAPS_MAKE, 8'h10, SC_RSHIFT_MAKE, 8'h1E, SC_INS_MAKE, 8'h0C,
            SC_CTRL_MAKE, 8'h1E, SC_CTRL_BREAK, SC_RSHIFT_BREAK,
            SC_CAPS_MAKE | BREAK_BIT, SC_INS_MAKE | BREAK_BIT, SC_CAPS_MAKE, 8'h0E
        };
        logic [7:0] shift_code;
        logic [7:0] key;
        bit         use_shift;
        bit         use_ctrl;
        bit         use_alt;
        bit         pressure_done;

        pressure_done = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, every modifier and each table choice first.
        foreach (directed_codes[i]) send_scancode(directed_codes[i]);

        // Mostly typing sessions under random modifiers, some noise and toggles.
        while (words_sent < TOTAL_WORDS) begin
            if (!pressure_done && words_sent >= PRESSURE_AT) begin
                hold_request  = 1'b1;
                pressure_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: send_scancode(8'($urandom_range(0, 255)));
                1: send_scancode($urandom_range(0, 1) ? SC_CAPS_MAKE : SC_INS_MAKE);
                default: begin
                    use_shift  = $urandom_range(0, 1);
                    use_ctrl   = ($urandom_range(0, 3) == 0);
                    use_alt    = ($urandom_range(0, 3) == 0);
                    shift_code = $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
                    if (use_shift) send_scancode(shift_code);
                    if (use_ctrl) send_scancode(SC_CTRL_MAKE);
                    if (use_alt) send_scancode(SC_ALT_MAKE);
                    repeat ($urandom_range(1, 6)) begin
                        key = 8'($urandom_range(0, SC_LAST));
                        send_scancode(key);
                        if ($urandom_range(0, 1)) send_scancode(key | BREAK_BIT);
                    end
                    // Now and then a release gets lost, leaving the modifier held.
                    if (use_shift && $urandom_range(0, 7) != 0) begin
                        send_scancode(shift_code | BREAK_BIT);
                    end
                    if (use_ctrl && $urandom_range(0, 7) != 0) send_scancode(SC_CTRL_BREAK);
                    if (use_alt && $urandom_range(0, 7) != 0) send_scancode(SC_ALT_BREAK);
                end
            endcase
        end
        in_valid <= 1'b0;

        // Drain the outstanding result words, then allow for the pipeline latency.
        @(posedge clk);
        while (keystrokes_pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && keystrokes_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
